FILE: hw/rtl/ppmfg_pkg.sv
// Shared types and constants for the PPM frame generator.
package ppmfg_pkg;

   // Fixed field widths of the request, result and register interface.
   localparam int CH_INDEX_BITS     = 3;
   localparam int CH_VALUE_BITS     = 12;
   localparam int FRAME_LENGTH_BITS = 16;
   localparam int GAP_BITS          = 12;
   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 32;

   // Reset values.
   localparam int RESET_CH_VALUE     = 1500;
   localparam int RESET_FRAME_LENGTH = 22500;
   localparam int RESET_GAP_WIDTH    = 300;

   // Request word operations.
   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   // Register index, taken from paddr bit 2 (registers sit 4 bytes apart).
   typedef enum logic [0:0] {
      REG_FRAME_LENGTH = 1'b0,
      REG_GAP_WIDTH    = 1'b1
   } reg_index_type;

endpackage

FILE: hw/rtl/ppmfg_ram.sv
// Generic synchronous RAM: one write port, two registered read ports, read-first.
module ppmfg_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   // Reads sample the array before this edge's write lands.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= mem_ff[rd_a_addr];
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

FILE: hw/rtl/ppm_frame_generator.sv
// Top level of the PPM frame generator: handshake, segment sequencer and channel store.
//
// Usage: every request word is either a one-microsecond tick (OP_TICK) or a channel
// load (OP_LOAD). Each accepted word yields exactly one result word carrying the
// pin level after that word and a frame_start flag that is high on the tick that
// begins a frame's sync pulse. A frame is the sync pulse (high), then for each
// channel a low gap and a high pulse so the channel interval equals its value, then
// a closing low gap. Loaded values take effect at the next frame start.
// Throughput is one word per cycle unless req_stall is high; each result is registered
// in the output or the skid register. The rate is set by the channel RAM, whose two
// read ports serve the next channel's value and the old pending value of a load in the
// same cycle, so ticks and loads can interleave freely. The result side has an output
// register and a one-word skid register: req_stall rises only when both hold a word, so
// requests keep flowing until the skid register fills after the receiver stalls.
// Configuration sits on an APB-style port: frame_length at byte 0 and gap_width at
// byte 4, to be written by the user only while the block is idle; the block itself does
// not enforce it. Reset (synchronous) sets frame_length to 22500, gap_width to 300,
// every channel to 1500, and parks the sequencer so that the first tick starts a frame.
// No RAM clearing pass is needed: per-entry written bits stand in for the reset value.
module ppm_frame_generator #(
   parameter int NUM_CHANNELS = 8,
   parameter int VALUE_BITS   = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request channel.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  ppmfg_pkg::op_type                       req_operation,
   input  logic [ppmfg_pkg::CH_INDEX_BITS-1:0]     req_channel_index,
   input  logic [ppmfg_pkg::CH_VALUE_BITS-1:0]     req_channel_value,
   // Result channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_pin_level,
   output logic                                    rsp_frame_start,
   // Configuration port.
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [ppmfg_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [ppmfg_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [ppmfg_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                    pready
);

   import ppmfg_pkg::*;

   // Channel store geometry: two banks per channel, address = {bank, channel}.
   localparam int CH_BITS   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int RAM_ABITS = CH_BITS + 1;
   localparam int RAM_DEPTH = 1 << RAM_ABITS;
   // Segment sequence: sync, then gap and pulse per channel, then closing gap.
   localparam int SEG_COUNT = 2 * NUM_CHANNELS + 2;
   localparam int SEG_BITS  = $clog2(SEG_COUNT);
   localparam logic [SEG_BITS-1:0] LAST_SEG = SEG_BITS'(SEG_COUNT - 1);
   // Arithmetic widths.
   localparam int SUM_BITS = VALUE_BITS + $clog2(NUM_CHANNELS + 1);
   localparam int CMP_BITS = ((SUM_BITS > FRAME_LENGTH_BITS) ? SUM_BITS
                                                             : FRAME_LENGTH_BITS) + 2;
   localparam int VG_BITS  = (VALUE_BITS > GAP_BITS) ? VALUE_BITS : GAP_BITS;
   localparam logic [VALUE_BITS-1:0] RST_VAL = VALUE_BITS'(RESET_CH_VALUE);
   localparam logic [SUM_BITS-1:0]   RST_SUM = SUM_BITS'(NUM_CHANNELS
                                                         * (RESET_CH_VALUE % (1 << VALUE_BITS)));

   // ---------------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------------
   logic [FRAME_LENGTH_BITS-1:0] frame_length_ff, frame_length_in;
   logic [GAP_BITS-1:0]          gap_width_ff, gap_width_in;
   logic                         csr_write;
   reg_index_type                csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);

   always_comb begin
      frame_length_in = frame_length_ff;
      gap_width_in    = gap_width_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_LENGTH: frame_length_in = pwdata[FRAME_LENGTH_BITS-1:0];
            REG_GAP_WIDTH:    gap_width_in    = pwdata[GAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FRAME_LENGTH: prdata = CSR_DATA_BITS'(frame_length_ff);
         REG_GAP_WIDTH:    prdata = CSR_DATA_BITS'(gap_width_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LENGTH_BITS'(RESET_FRAME_LENGTH);
         gap_width_ff    <= GAP_BITS'(RESET_GAP_WIDTH);
      end else begin
         frame_length_ff <= frame_length_in;
         gap_width_ff    <= gap_width_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Handshake and request decode.
   // ---------------------------------------------------------------------------
   logic out_vld_ff, out_vld_in;
   logic skid_vld_ff, skid_vld_in;
   logic out_pin_ff, out_pin_in, out_start_ff, out_start_in;
   logic skid_pin_ff, skid_pin_in, skid_start_ff, skid_start_in;
   logic acc, tick, load, out_take;
   logic res_pin, res_start;

   assign req_stall = skid_vld_ff;
   assign acc       = req_valid && !skid_vld_ff;
   assign tick      = acc && (req_operation == OP_TICK);
   assign load      = acc && (req_operation == OP_LOAD);
   assign out_take  = out_vld_ff && !rsp_stall;

   // ---------------------------------------------------------------------------
   // Channel bookkeeping. Each channel owns two RAM entries. act_bank names the
   // entry that holds the value in use this frame; a load always writes the other
   // entry and marks the channel dirty. At a frame start every dirty channel
   // swaps banks, which is the pending-to-active copy without a sweep. Entries
   // never written read as the reset value through the written bits.
   // ---------------------------------------------------------------------------
   logic [NUM_CHANNELS-1:0] act_bank_ff, act_bank_in;
   logic [NUM_CHANNELS-1:0] dirty_ff, dirty_in;
   logic [RAM_DEPTH-1:0]    written_ff, written_in;

   logic [CH_BITS-1:0]    ld_ch;
   logic                  ld_in_range;
   logic                  ld_we;
   logic [RAM_ABITS-1:0]  wr_addr, rd_b_addr;
   logic [VALUE_BITS-1:0] wr_data;

   // Pending-sum maintenance runs in the cycle after the load that caused it.
   logic                  upd_vld_ff, upd_vld_in;
   logic [VALUE_BITS-1:0] upd_new_ff;
   logic                  upd_old_ok_ff;
   logic [VALUE_BITS-1:0] rd_b_data, upd_old;
   logic [SUM_BITS-1:0]   pending_sum_ff, pending_sum_in, sum_delta;

   assign ld_in_range = (32'(req_channel_index) < NUM_CHANNELS);
   assign ld_ch       = ld_in_range ? CH_BITS'(req_channel_index) : '0;
   assign ld_we       = load && ld_in_range;
   assign wr_addr     = {~act_bank_ff[ld_ch], ld_ch};
   assign rd_b_addr   = {dirty_ff[ld_ch] ? ~act_bank_ff[ld_ch] : act_bank_ff[ld_ch], ld_ch};
   assign wr_data     = VALUE_BITS'(req_channel_value);
   assign upd_vld_in  = ld_we;

   assign upd_old   = upd_old_ok_ff ? rd_b_data : RST_VAL;
   assign sum_delta = upd_vld_ff ? (SUM_BITS'(upd_new_ff) - SUM_BITS'(upd_old)) : '0;
   // Forwarded so a frame start right after a load sees the new value.
   assign pending_sum_in = pending_sum_ff + sum_delta;

   // ---------------------------------------------------------------------------
   // Segment sequencer.
   // ---------------------------------------------------------------------------
   logic [SEG_BITS-1:0]          segment_index_ff, segment_index_in;
   logic [FRAME_LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic                         level_ff, level_in;

   logic                         seg_begin, frame_go;
   logic [GAP_BITS-1:0]          gap_e;
   logic [CMP_BITS-1:0]          sync_diff;
   logic                         sync_short;
   logic [FRAME_LENGTH_BITS-1:0] sync_len, gap_len, chan_len, seg_len, rem_next;
   logic                         seg_high;

   logic [RAM_ABITS-1:0]  rd_a_addr, rd_a_addr_ff;
   logic [CH_BITS-1:0]    rd_a_ch;
   logic [SEG_BITS-1:0]   rd_a_half;
   logic [VALUE_BITS-1:0] rd_a_data, chan_val;
   logic [VG_BITS-1:0]    v_ext, g_ext;

   assign gap_e     = (gap_width_ff == '0) ? GAP_BITS'(1) : gap_width_ff;
   assign gap_len   = FRAME_LENGTH_BITS'(gap_e);
   assign seg_begin = (remaining_ff == '0);
   assign frame_go  = tick && seg_begin && (segment_index_ff == '0);

   // Sync length: frame_length - sum - gap, but never shorter than one gap.
   assign sync_diff  = CMP_BITS'(frame_length_ff) - CMP_BITS'(pending_sum_in)
                       - CMP_BITS'(gap_e);
   assign sync_short = sync_diff[CMP_BITS-1] || (sync_diff < CMP_BITS'(gap_e));
   assign sync_len   = sync_short ? gap_len : sync_diff[FRAME_LENGTH_BITS-1:0];

   // The channel pulse value was prefetched last cycle; pulse is value - gap,
   // and one tick when the value does not exceed the gap.
   assign chan_val = written_ff[rd_a_addr_ff] ? rd_a_data : RST_VAL;
   assign v_ext    = VG_BITS'(chan_val);
   assign g_ext    = VG_BITS'(gap_e);
   assign chan_len = (v_ext > g_ext) ? FRAME_LENGTH_BITS'(v_ext - g_ext)
                                     : FRAME_LENGTH_BITS'(1);

   always_comb begin
      if (segment_index_ff == '0) begin
         seg_len  = sync_len;
         seg_high = 1'b1;
      end else if (segment_index_ff[0]) begin
         seg_len  = gap_len;
         seg_high = 1'b0;
      end else begin
         seg_len  = chan_len;
         seg_high = 1'b1;
      end
   end

   // Every segment length is at least one, so the decrement never underflows.
   assign rem_next = (seg_begin ? seg_len : remaining_ff) - FRAME_LENGTH_BITS'(1);

   always_comb begin
      segment_index_in = segment_index_ff;
      remaining_in     = remaining_ff;
      level_in         = level_ff;
      if (tick) begin
         remaining_in = rem_next;
         if (seg_begin) begin
            level_in = seg_high;
         end
         if (rem_next == '0) begin
            segment_index_in = (segment_index_ff == LAST_SEG) ? '0
                                                              : segment_index_ff + 1'b1;
         end
      end
   end

   // Bank swap at a frame start, bank marking on a load.
   always_comb begin
      act_bank_in = act_bank_ff;
      dirty_in    = dirty_ff;
      written_in  = written_ff;
      if (frame_go) begin
         act_bank_in = act_bank_ff ^ dirty_ff;
         dirty_in    = '0;
      end
      if (ld_we) begin
         dirty_in[ld_ch]     = 1'b1;
         written_in[wr_addr] = 1'b1;
      end
   end

   // Prefetch address follows the next state, so the value of the channel whose
   // pulse may start on the next word is ready in the RAM's output register.
   assign rd_a_half = (segment_index_in >> 1) - SEG_BITS'(1);
   assign rd_a_ch   = (32'(rd_a_half) < NUM_CHANNELS) ? CH_BITS'(rd_a_half) : '0;
   assign rd_a_addr = {act_bank_in[rd_a_ch], rd_a_ch};

   ppmfg_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ch_ram (
      .clock     (clock),
      .wr_en     (ld_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   // ---------------------------------------------------------------------------
   // Result word and output buffering.
   // ---------------------------------------------------------------------------
   assign res_pin   = level_in;
   assign res_start = frame_go;

   always_comb begin
      out_vld_in    = out_vld_ff;
      out_pin_in    = out_pin_ff;
      out_start_in  = out_start_ff;
      skid_vld_in   = skid_vld_ff;
      skid_pin_in   = skid_pin_ff;
      skid_start_in = skid_start_ff;
      if (!out_vld_ff || out_take) begin
         if (skid_vld_ff) begin
            out_vld_in   = 1'b1;
            out_pin_in   = skid_pin_ff;
            out_start_in = skid_start_ff;
            skid_vld_in  = 1'b0;
         end else if (acc) begin
            out_vld_in   = 1'b1;
            out_pin_in   = res_pin;
            out_start_in = res_start;
         end else begin
            out_vld_in = 1'b0;
         end
      end else if (acc) begin
         skid_vld_in   = 1'b1;
         skid_pin_in   = res_pin;
         skid_start_in = res_start;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_pin_level   = out_pin_ff;
   assign rsp_frame_start = out_start_ff;

   // ---------------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff       <= 1'b0;
         skid_vld_ff      <= 1'b0;
         act_bank_ff      <= '0;
         dirty_ff         <= '0;
         written_ff       <= '0;
         upd_vld_ff       <= 1'b0;
         pending_sum_ff   <= RST_SUM;
         segment_index_ff <= '0;
         remaining_ff     <= '0;
         level_ff         <= 1'b0;
      end else begin
         out_vld_ff       <= out_vld_in;
         skid_vld_ff      <= skid_vld_in;
         act_bank_ff      <= act_bank_in;
         dirty_ff         <= dirty_in;
         written_ff       <= written_in;
         upd_vld_ff       <= upd_vld_in;
         pending_sum_ff   <= pending_sum_in;
         segment_index_ff <= segment_index_in;
         remaining_ff     <= remaining_in;
         level_ff         <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pin_ff    <= out_pin_in;
      out_start_ff  <= out_start_in;
      skid_pin_ff   <= skid_pin_in;
      skid_start_ff <= skid_start_in;
      upd_new_ff    <= wr_data;
      upd_old_ok_ff <= written_ff[rd_b_addr];
      rd_a_addr_ff  <= rd_a_addr;
   end

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   // The skid register only fills behind a held output word.
   assert property (@(posedge clock) disable iff (reset) skid_vld_ff |-> out_vld_ff)
      else $error("skid word held without an output word");

   // A frame always opens with the sync pulse high.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_frame_start |-> rsp_pin_level)
      else $error("frame start reported with the pin low");

   // Every pending value is promoted at a frame start.
   assert property (@(posedge clock) disable iff (reset) frame_go |=> (dirty_ff == '0))
      else $error("dirty channel left after a frame start");

   // A load never moves the waveform.
   assert property (@(posedge clock) disable iff (reset)
                    load |=> (level_ff == $past(level_ff))
                             && (segment_index_ff == $past(segment_index_ff))
                             && (remaining_ff == $past(remaining_ff)))
      else $error("load word disturbed the segment sequencer");

endmodule
